/* src/assert_macros.svh */
// Assertion macros shared by the heap controller and datapath.
// Each macro expects signals named clock and reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/knch_pkg.sv */
// Package for the k-nearest candidate heap: opcodes, status codes and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package knch_pkg;

   // request opcodes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // response status codes
   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_REPLACED = 3'd1;
   localparam logic [2:0] ST_REJECTED = 3'd2;
   localparam logic [2:0] ST_READ_OK  = 3'd3;
   localparam logic [2:0] ST_READ_OUT = 3'd4;
   localparam logic [2:0] ST_CLEARED  = 3'd5;

   // capacity after reset
   localparam logic [6:0] CAP_RESET = 7'd64;

   // controller -> datapath
   typedef struct packed {
      logic       load;        // capture request payload
      logic       grow;        // open tail hole, bump fill count
      logic       clear;       // empty the heap
      logic       rd_head;     // read heap position 0
      logic       rd_pos;      // read requested position
      logic       up_rd;       // read parent of hole
      logic       up_move;     // parent moves down into hole
      logic       hd_take;     // take head slot, start sift down
      logic       dn_rd;       // read both children of hole
      logic       dn_move;     // larger child moves up into hole
      logic       fin_wr;      // place new entry and its record
      logic       rec_rd;      // read record of slot just read
      logic       set_status;
      logic [2:0] status;
      logic       emit;        // load response register
   } knch_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] opcode;
      logic       grow;        // heap below capacity
      logic       fill_zero;
      logic       pos_ok;
      logic       up_more;     // new distance above parent
      logic       up_root_zero;
      logic       head_less;   // new distance below head
      logic       has_kid;
      logic       dn_less;     // new distance below larger child
      logic       rsp_free;
   } knch_stat_type;

endpackage

/* src/knch_if.sv */
// Request and response channel interfaces of the candidate heap.
// Valid/ready handshake; no package dependency.
`timescale 1ns / 1ps

interface knch_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [31:0] distance;
   logic [31:0] record;
   logic [5:0]  position;

   modport source (output valid, opcode, distance, record, position, input ready);
   modport sink   (input valid, opcode, distance, record, position, output ready);
endinterface

interface knch_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        max_valid;
   logic [31:0] max_distance;
   logic [31:0] read_distance;
   logic [5:0]  read_slot;
   logic [31:0] read_record;
   logic [6:0]  fill_level;

   modport source (output valid, status, max_valid, max_distance, read_distance,
                   read_slot, read_record, fill_level, input ready);
   modport sink   (input valid, status, max_valid, max_distance, read_distance,
                   read_slot, read_record, fill_level, output ready);
endinterface

/* src/knch_ram.sv */
// Generic RAM: one write port, two read ports with registered, enabled reads.
// No dependencies.
`timescale 1ns / 1ps

module knch_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* src/knch_ctrl.sv */
// Controller FSM of the candidate heap: sequences insert, sift, read, clear.
// Depends on knch_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module knch_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  knch_pkg::knch_stat_type stat,
   output knch_pkg::knch_cmd_type  cmd
);

   typedef enum logic [9:0] {
      S_IDLE    = 10'b00_0000_0001,
      S_DECODE  = 10'b00_0000_0010,
      S_UP_RD   = 10'b00_0000_0100,
      S_UP_EV   = 10'b00_0000_1000,
      S_HEAD_EV = 10'b00_0001_0000,
      S_DN_RD   = 10'b00_0010_0000,
      S_DN_EV   = 10'b00_0100_0000,
      S_FIN     = 10'b00_1000_0000,
      S_RD_SLOT = 10'b01_0000_0000,
      S_RESP    = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.set_status = 1'b1;
            unique case (stat.opcode)
               knch_pkg::OP_INSERT: begin
                  if (stat.grow) begin
                     cmd.grow   = 1'b1;
                     cmd.status = knch_pkg::ST_INSERTED;
                     state_in   = stat.fill_zero ? S_FIN : S_UP_RD;
                  end else if (stat.fill_zero) begin
                     cmd.status = knch_pkg::ST_REJECTED;
                     state_in   = S_RESP;
                  end else begin
                     cmd.rd_head    = 1'b1;
                     cmd.set_status = 1'b0;
                     state_in       = S_HEAD_EV;
                  end
               end
               knch_pkg::OP_READ: begin
                  if (stat.pos_ok) begin
                     cmd.rd_pos = 1'b1;
                     cmd.status = knch_pkg::ST_READ_OK;
                     state_in   = S_RD_SLOT;
                  end else begin
                     cmd.status = knch_pkg::ST_READ_OUT;
                     state_in   = S_RESP;
                  end
               end
               knch_pkg::OP_CLEAR: begin
                  cmd.clear  = 1'b1;
                  cmd.status = knch_pkg::ST_CLEARED;
                  state_in   = S_RESP;
               end
               default: begin
                  cmd.status = knch_pkg::ST_READ_OUT;
                  state_in   = S_RESP;
               end
            endcase
         end
         S_UP_RD: begin
            cmd.up_rd = 1'b1;
            state_in  = S_UP_EV;
         end
         S_UP_EV: begin
            if (stat.up_more) begin
               cmd.up_move = 1'b1;
               state_in    = stat.up_root_zero ? S_FIN : S_UP_RD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_HEAD_EV: begin
            cmd.set_status = 1'b1;
            if (stat.head_less) begin
               cmd.hd_take = 1'b1;
               cmd.status  = knch_pkg::ST_REPLACED;
               state_in    = S_DN_RD;
            end else begin
               cmd.status = knch_pkg::ST_REJECTED;
               state_in   = S_RESP;
            end
         end
         S_DN_RD: begin
            if (stat.has_kid) begin
               cmd.dn_rd = 1'b1;
               state_in  = S_DN_EV;
            end else begin
               state_in = S_FIN;
            end
         end
         S_DN_EV: begin
            if (stat.dn_less) begin
               cmd.dn_move = 1'b1;
               state_in    = S_DN_RD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.fin_wr = 1'b1;
            state_in   = S_RESP;
         end
         S_RD_SLOT: begin
            cmd.rec_rd = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_NEXT(a_accept_decodes, (state_ff == S_IDLE) && req_valid, state_ff == S_DECODE, "accepted request did not go to decode")
   `ASSERT_NEXT(a_resp_returns, (state_ff == S_RESP) && stat.rsp_free, state_ff == S_IDLE, "response emitted but controller not idle")

endmodule

/* src/knch_dp.sv */
// Datapath of the candidate heap: heap and record memories, fill count,
// capacity register, hole pointer and response register.
// Depends on knch_pkg, knch_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module knch_dp #(
   parameter int DEPTH       = 64,
   parameter int RECORD_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [6:0]              csr_write_data,
   input  logic [1:0]              req_opcode,
   input  logic [31:0]             req_distance,
   input  logic [31:0]             req_record,
   input  logic [5:0]              req_position,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_status,
   output logic                    rsp_max_valid,
   output logic [31:0]             rsp_max_distance,
   output logic [31:0]             rsp_read_distance,
   output logic [5:0]              rsp_read_slot,
   output logic [31:0]             rsp_read_record,
   output logic [6:0]              rsp_fill_level,
   input  knch_pkg::knch_cmd_type  cmd,
   output knch_pkg::knch_stat_type stat
);

   localparam int AW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);
   localparam int HW = 32 + AW;
   localparam int CW = (FW > 7) ? FW : 7;
   localparam int PW = (FW > 6) ? FW : 6;
   localparam int KW = AW + 2;
   localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);

   // request and control registers
   logic [1:0]             op_ff;
   logic [31:0]            dist_ff;
   logic [31:0]            rec_ff;
   logic [5:0]             pos_ff;
   logic [FW-1:0]          fill_ff;
   logic [6:0]             cap_ff;
   logic [AW-1:0]          hole_ff;
   logic [AW-1:0]          slot_ff;
   logic [31:0]            max_ff;
   logic [2:0]             res_status_ff;
   logic                   rsp_valid_ff;
   logic [2:0]             rsp_status_ff;
   logic [31:0]            rsp_max_ff;
   logic [31:0]            rsp_rdist_ff;
   logic [5:0]             rsp_rslot_ff;
   logic [31:0]            rsp_rrec_ff;
   logic [6:0]             rsp_fill_ff;

   // memory ports
   logic                   heap_we;
   logic [AW-1:0]          heap_rd_addr_a;
   logic [HW-1:0]          heap_wdata;
   logic                   heap_re;
   logic [HW-1:0]          qa;
   logic [HW-1:0]          qb;
   logic [RECORD_BITS-1:0] rec_q;
   logic [RECORD_BITS-1:0] rec_q_unused;

   logic [31:0]            qa_dist;
   logic [31:0]            qb_dist;
   logic [AW-1:0]          qa_slot;
   logic [CW-1:0]          cap_w;
   logic [CW-1:0]          eff_k;
   logic [AW-1:0]          up_root;
   logic [KW-1:0]          kid1;
   logic [KW-1:0]          kid2;
   logic [KW-1:0]          fill_k;
   logic                   has_kid2;
   logic                   use_b;
   logic [HW-1:0]          child;
   logic [31:0]            child_dist;
   logic [AW-1:0]          child_idx;
   logic                   is_ok;

   assign qa_dist = qa[HW-1:AW];
   assign qa_slot = qa[AW-1:0];
   assign qb_dist = qb[HW-1:AW];

   // effective capacity saturates at DEPTH
   assign cap_w = CW'(cap_ff);
   assign eff_k = (cap_w > CW'(DEPTH)) ? CW'(DEPTH) : cap_w;

   // tree navigation around the hole
   assign up_root  = (hole_ff - AW'(1)) >> 1;
   assign kid1     = {1'b0, hole_ff, 1'b1};
   assign kid2     = kid1 + KW'(1);
   assign fill_k   = KW'(fill_ff);
   assign has_kid2 = kid2 < fill_k;
   assign use_b    = has_kid2 && (qb_dist > qa_dist);
   assign child    = use_b ? qb : qa;
   assign child_dist = child[HW-1:AW];
   assign child_idx  = use_b ? AW'(kid2) : AW'(kid1);

   // status to controller
   always_comb begin
      stat.opcode       = op_ff;
      stat.grow         = CW'(fill_ff) < eff_k;
      stat.fill_zero    = (fill_ff == '0);
      stat.pos_ok       = PW'(pos_ff) < PW'(fill_ff);
      stat.up_more      = dist_ff > qa_dist;
      stat.up_root_zero = (up_root == '0);
      stat.head_less    = dist_ff < qa_dist;
      stat.has_kid      = kid1 < fill_k;
      stat.dn_less      = dist_ff < child_dist;
      stat.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   // heap memory read address and write data
   always_comb begin
      heap_re = cmd.rd_head || cmd.rd_pos || cmd.up_rd || cmd.dn_rd;
      priority if (cmd.rd_head) begin
         heap_rd_addr_a = '0;
      end else if (cmd.rd_pos) begin
         heap_rd_addr_a = AW'(pos_ff);
      end else if (cmd.up_rd) begin
         heap_rd_addr_a = up_root;
      end else begin
         heap_rd_addr_a = AW'(kid1);
      end
      heap_we = cmd.up_move || cmd.dn_move || cmd.fin_wr;
      priority if (cmd.up_move) begin
         heap_wdata = qa;
      end else if (cmd.dn_move) begin
         heap_wdata = child;
      end else begin
         heap_wdata = {dist_ff, slot_ff};
      end
   end

   knch_ram #(.WIDTH(HW), .DEPTH(DEPTH)) u_heap_ram (
      .clock     (clock),
      .wr_en     (heap_we),
      .wr_addr   (hole_ff),
      .wr_data   (heap_wdata),
      .rd_en     (heap_re),
      .rd_addr_a (heap_rd_addr_a),
      .rd_addr_b (AW'(kid2)),
      .rd_data_a (qa),
      .rd_data_b (qb)
   );

   knch_ram #(.WIDTH(RECORD_BITS), .DEPTH(DEPTH)) u_rec_ram (
      .clock     (clock),
      .wr_en     (cmd.fin_wr),
      .wr_addr   (slot_ff),
      .wr_data   (RECORD_BITS'(rec_ff)),
      .rd_en     (cmd.rec_rd),
      .rd_addr_a (qa_slot),
      .rd_addr_b (qa_slot),
      .rd_data_a (rec_q),
      .rd_data_b (rec_q_unused)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         cap_ff       <= knch_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
         if (cmd.clear) begin
            fill_ff <= '0;
         end else if (cmd.grow) begin
            fill_ff <= fill_ff + FW'(1);
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_opcode;
         dist_ff <= req_distance;
         rec_ff  <= req_record;
         pos_ff  <= req_position;
      end
      if (cmd.set_status) begin
         res_status_ff <= cmd.status;
      end
      // hole pointer and slot
      if (cmd.grow) begin
         hole_ff <= AW'(fill_ff);
         slot_ff <= AW'(fill_ff);
      end else if (cmd.hd_take) begin
         hole_ff <= '0;
         slot_ff <= qa_slot;
      end else if (cmd.up_move) begin
         hole_ff <= up_root;
      end else if (cmd.dn_move) begin
         hole_ff <= child_idx;
      end
      // head distance after replacement
      if (cmd.hd_take) begin
         max_ff <= dist_ff;
      end else if (cmd.dn_move && (hole_ff == '0)) begin
         max_ff <= child_dist;
      end
      if (cmd.emit) begin
         rsp_status_ff <= res_status_ff;
         rsp_max_ff    <= (res_status_ff == knch_pkg::ST_REPLACED) ? max_ff : '0;
         rsp_rdist_ff  <= is_ok ? qa_dist : '0;
         rsp_rslot_ff  <= is_ok ? 6'(qa_slot) : '0;
         rsp_rrec_ff   <= is_ok ? 32'(rec_q) : '0;
         rsp_fill_ff   <= 7'(fill_ff);
      end
   end

   assign is_ok = (res_status_ff == knch_pkg::ST_READ_OK);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_max_valid     = (rsp_status_ff == knch_pkg::ST_REPLACED);
   assign rsp_max_distance  = rsp_max_ff;
   assign rsp_read_distance = rsp_rdist_ff;
   assign rsp_read_slot     = rsp_rslot_ff;
   assign rsp_read_record   = rsp_rrec_ff;
   assign rsp_fill_level    = rsp_fill_ff;

   `ASSERT_ALWAYS(a_fill_bound, fill_ff <= FILL_MAX, "fill count above heap depth")
   `ASSERT_NEXT(a_up_climbs, cmd.up_move, hole_ff < $past(hole_ff), "sift up did not move toward head")
   `ASSERT_NEXT(a_emit_valid, cmd.emit, rsp_valid_ff, "emitted response not valid")

endmodule

/* src/k_nearest_candidate_heap.sv */
// Bounded max-heap of the k closest candidates, k set by the capacity register.
// Requests are served one at a time: a new request is accepted only after the
// response to the last one has been loaded. Every sift level is one read and
// one compare-write round trip through the heap memory. Capacity must be
// written only while idle; the user is bound to this, the block itself does
// not enforce it.
// Depends on knch_pkg, knch_if, knch_ram, knch_ctrl and knch_dp.
`timescale 1ns / 1ps

module k_nearest_candidate_heap #(
   parameter int DEPTH       = 64,
   parameter int RECORD_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [6:0] csr_write_data,
   knch_req_if.sink   req_if,
   knch_rsp_if.source rsp_if
);

   knch_pkg::knch_cmd_type  cmd;
   knch_pkg::knch_stat_type stat;

   knch_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   knch_dp #(.DEPTH(DEPTH), .RECORD_BITS(RECORD_BITS)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_opcode        (req_if.opcode),
      .req_distance      (req_if.distance),
      .req_record        (req_if.record),
      .req_position      (req_if.position),
      .rsp_ready         (rsp_if.ready),
      .rsp_valid         (rsp_if.valid),
      .rsp_status        (rsp_if.status),
      .rsp_max_valid     (rsp_if.max_valid),
      .rsp_max_distance  (rsp_if.max_distance),
      .rsp_read_distance (rsp_if.read_distance),
      .rsp_read_slot     (rsp_if.read_slot),
      .rsp_read_record   (rsp_if.read_record),
      .rsp_fill_level    (rsp_if.fill_level),
      .cmd               (cmd),
      .stat              (stat)
   );

endmodule
